@@ hw/rtl/tbit_pkg.sv @@
// shared constants, operation codes and types of the timebase and interval timer
package tbit_pkg;

  localparam int OP_W    = 3;
  localparam int WORD_W  = 36;
  localparam int LOW_W   = 35;
  localparam int TB_W    = 59;
  localparam int TTG_W   = 37;
  localparam int HW_BITS = 12;
  localparam int TB_LO_W = LOW_W - HW_BITS;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_RD_TB  = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_TB  = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_IV  = 3'd3;
  localparam logic [OP_W-1:0] OP_WR_IV  = 3'd4;

  localparam logic signed [TTG_W-1:0] HW_INCR  = 37'sd4096;
  localparam logic [WORD_W-1:0]       Q_INCR   = 36'd4096;

  typedef struct packed {
    logic [WORD_W-1:0] read_high;
    logic [LOW_W-1:0]  read_low;
    logic              expired;
    logic [WORD_W-1:0] quantum;
  } res_t;

endpackage

@@ hw/rtl/tbit_if.sv @@
// valid/ready channel interfaces for timer requests and results
interface tbit_in_if import tbit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] word_high;
  logic [WORD_W-1:0] word_low;
  logic              pi_active;

  modport source (output valid, op, word_high, word_low, pi_active, input ready);
  modport sink   (input valid, op, word_high, word_low, pi_active, output ready);
endinterface

interface tbit_out_if import tbit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_high;
  logic [LOW_W-1:0]  read_low;
  logic              expired;
  logic [WORD_W-1:0] quantum;

  modport source (output valid, read_high, read_low, expired, quantum, input ready);
  modport sink   (input valid, read_high, read_low, expired, quantum, output ready);
endinterface

@@ hw/rtl/timebase_interval_timer.sv @@
// top level of the timebase and interval timer: handshakes, mode register, result register
//
// in_item carries one request word per handshake: op selects tick, read or
// write of the 59-bit timebase, or read or write of the interval period.
// out_res returns exactly one result word per request, in order: the read
// data, the expired flag of a tick and the quantum count after the request.
// cfg_wr_en with cfg_wr_data writes its_mode, which enables quantum counting
// on ticks; write it only while no request is outstanding.
// The state is updated in the cycle a request is taken and the result sits in
// the output register from the next cycle on.
// One request is taken every cycle while the output register is empty or is
// being emptied in the same cycle.
// When the receiver stalls, the result is held and in_item.ready drops until
// the result is taken; nothing is lost.
// Synchronous reset clears the timebase, period, time-to-go, quantum count,
// its_mode and the output valid flag.
module timebase_interval_timer import tbit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tbit_in_if.sink     in_item,
  tbit_out_if.source  out_res,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic its_mode_r;
  logic out_valid_r;
  res_t res_r;
  res_t res;
  logic accept;

  assign in_item.ready = !out_valid_r || out_res.ready;
  assign accept        = in_item.valid && in_item.ready;

  tbit_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .its_mode  (its_mode_r),
    .op        (in_item.op),
    .word_high (in_item.word_high),
    .word_low  (in_item.word_low),
    .pi_active (in_item.pi_active),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      its_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      its_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.read_high = res_r.read_high;
  assign out_res.read_low  = res_r.read_low;
  assign out_res.expired   = res_r.expired;
  assign out_res.quantum   = res_r.quantum;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_res.valid)
    else $error("accepted word produced no result");

  a_expired_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.op != OP_TICK) |=> !out_res.expired)
    else $error("expired raised by a non-tick word");

  a_read_keeps_quantum: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.op == OP_RD_TB) ##1 accept && (in_item.op == OP_RD_IV)
    |=> out_res.quantum == $past(out_res.quantum))
    else $error("quantum changed across reads");

  a_no_read_data_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.op == OP_WR_TB || in_item.op == OP_WR_IV)
    |=> out_res.read_high == '0 && out_res.read_low == '0)
    else $error("read data returned on a write");
`endif

endmodule

@@ hw/rtl/tbit_core.sv @@
// timer state registers and the per-word update and read logic
module tbit_core import tbit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              its_mode,
  input  logic [OP_W-1:0]   op,
  input  logic [WORD_W-1:0] word_high,
  input  logic [WORD_W-1:0] word_low,
  input  logic              pi_active,
  output res_t              res
);

  logic [TB_W-1:0]          tb_r, tb_nxt;
  logic [WORD_W-1:0]        period_r, period_nxt;
  logic signed [TTG_W-1:0]  ttg_r, ttg_nxt, ttg_dec;
  logic [WORD_W-1:0]        quantum_r, quantum_nxt;

  assign ttg_dec = ttg_r - HW_INCR;

  always_comb begin
    tb_nxt      = tb_r;
    period_nxt  = period_r;
    ttg_nxt     = ttg_r;
    quantum_nxt = quantum_r;
    res         = '0;
    unique case (op)
      OP_TICK: begin
        tb_nxt = tb_r + TB_W'(1);
        if (ttg_dec <= 0) begin
          ttg_nxt     = signed'({1'b0, period_r});
          res.expired = 1'b1;
        end else begin
          ttg_nxt = ttg_dec;
        end
        if (its_mode && !pi_active) begin
          quantum_nxt = quantum_r + Q_INCR;
        end
      end
      OP_RD_TB: begin
        res.read_high = tb_r[TB_W-1 -: WORD_W];
        res.read_low  = {tb_r[TB_LO_W-1:0], {HW_BITS{1'b0}}};
      end
      OP_WR_TB: begin
        tb_nxt = {word_high, word_low[LOW_W-1:HW_BITS]};
      end
      OP_RD_IV: begin
        res.read_high = period_r;
      end
      OP_WR_IV: begin
        period_nxt = word_high;
        ttg_nxt    = signed'({1'b0, word_high});
      end
      default: begin
      end
    endcase
    res.quantum = quantum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r      <= '0;
      period_r  <= '0;
      ttg_r     <= '0;
      quantum_r <= '0;
    end else if (accept) begin
      tb_r      <= tb_nxt;
      period_r  <= period_nxt;
      ttg_r     <= ttg_nxt;
      quantum_r <= quantum_nxt;
    end
  end

endmodule
